// File: rtl/wsfu_pkg.sv
package wsfu_pkg;

  // Header field constants
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [6:0] LEN_CAP   = 7'd125;
  localparam logic [6:0] MAX_PAYLOAD_RST = 7'd124;

  // Config register map
  localparam int         ADDR_W       = 3;
  localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;

  // Frame status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_TEXT      = 3'd0;
  localparam status_t ST_CLOSE     = 3'd1;
  localparam status_t ST_BAD_HDR   = 3'd2;
  localparam status_t ST_TOO_LONG  = 3'd3;
  localparam status_t ST_TRUNCATED = 3'd4;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_MASK = 5'b00100,
    PH_DATA = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_t;

  // Input word
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic       has_byte;
    logic [7:0] payload_byte;
    logic       frame_done;
    status_t    status;
  } res_word_t;

endpackage

// File: rtl/wsfu_in_if.sv
interface wsfu_in_if
  import wsfu_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, rx_byte, buffer_end, input ready);
  modport sink   (input valid, rx_byte, buffer_end, output ready);
endinterface

// File: rtl/wsfu_out_if.sv
interface wsfu_out_if
  import wsfu_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] payload_byte;
  logic       frame_done;
  status_t    status;

  modport source (output valid, has_byte, payload_byte, frame_done, status, input ready);
  modport sink   (input valid, has_byte, payload_byte, frame_done, status, output ready);
endinterface

// File: rtl/wsfu_cfg.sv
module wsfu_cfg
  import wsfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [6:0]        max_payload
);

  logic [6:0] max_payload_r;
  logic [6:0] max_payload_nxt;
  logic       sel_max;

  assign sel_max = (paddr[ADDR_W-1] == REG_MAX_PAYLOAD);
  assign pready  = 1'b1;

  // Register write on the access cycle
  always_comb begin
    max_payload_nxt = max_payload_r;
    if (psel && penable && pwrite && sel_max) begin
      max_payload_nxt = pwdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else begin
      max_payload_r <= max_payload_nxt;
    end
  end

  // Read back
  assign prdata      = sel_max ? {25'd0, max_payload_r} : 32'd0;
  assign max_payload = max_payload_r;

endmodule

// File: rtl/wsfu_in_stage.sv
module wsfu_in_stage
  import wsfu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  wsfu_in_if.sink  in_ch,
  input  logic     advance,
  output logic     word_valid,
  output in_word_t word
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;
  logic     take;

  // Accept when empty or when the held word moves on this cycle
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= '{rx_byte: in_ch.rx_byte, buffer_end: in_ch.buffer_end};
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

// File: rtl/wsfu_parser.sv
module wsfu_parser
  import wsfu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      word_valid,
  input  in_word_t  word,
  input  logic      advance,
  input  logic [6:0] max_payload,
  output logic      res_valid,
  output res_word_t res
);

  phase_t      phase_r,    phase_nxt;
  logic [6:0]  count_r,    count_nxt;
  logic [6:0]  len_r,      len_nxt;
  logic [31:0] mask_r,     mask_nxt;
  logic        mask_en_r,  mask_en_nxt;
  logic        close_r,    close_nxt;
  logic        oversize_r, oversize_nxt;

  logic [7:0]  rx;
  logic        last;
  logic [3:0]  opc;
  logic [6:0]  lim;
  logic [6:0]  count_inc;
  logic [7:0]  mask_byte;
  logic        deliver;
  status_t     done_st;
  logic        step;

  assign rx        = word.rx_byte;
  assign last      = word.buffer_end;
  assign opc       = rx[3:0];
  assign lim       = (max_payload > LEN_CAP) ? LEN_CAP : max_payload;
  assign count_inc = count_r + 7'd1;
  assign deliver   = !oversize_r && !close_r;
  assign done_st   = oversize_r ? ST_TOO_LONG : (close_r ? ST_CLOSE : ST_TEXT);
  assign step      = word_valid && advance;

  // Mask byte for the current payload position
  always_comb begin
    case (count_r[1:0])
      2'd0:    mask_byte = mask_r[7:0];
      2'd1:    mask_byte = mask_r[15:8];
      2'd2:    mask_byte = mask_r[23:16];
      default: mask_byte = mask_r[31:24];
    endcase
  end

  // Frame parse: next state and result for one byte
  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    len_nxt      = len_r;
    mask_nxt     = mask_r;
    mask_en_nxt  = mask_en_r;
    close_nxt    = close_r;
    oversize_nxt = oversize_r;
    res_valid    = 1'b0;
    res          = '0;

    case (phase_r)
      PH_HDR0: begin
        if (!rx[7] || (opc != OPC_TEXT && opc != OPC_CLOSE)) begin
          res_valid  = 1'b1;
          res.frame_done = 1'b1;
          res.status = ST_BAD_HDR;
          phase_nxt  = last ? PH_HDR0 : PH_SKIP;
        end else begin
          close_nxt = (opc == OPC_CLOSE);
          if (last) begin
            res_valid  = 1'b1;
            res.frame_done = 1'b1;
            res.status = ST_TRUNCATED;
            phase_nxt  = PH_HDR0;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
      end
      PH_HDR1: begin
        mask_en_nxt  = rx[7];
        len_nxt      = rx[6:0];
        oversize_nxt = (rx[6:0] > lim);
        count_nxt    = 7'd0;
        mask_nxt     = 32'd0;
        if (last) begin
          res_valid  = 1'b1;
          res.frame_done = 1'b1;
          res.status = ST_TRUNCATED;
          phase_nxt  = PH_HDR0;
        end else begin
          phase_nxt = PH_MASK;
        end
      end
      PH_MASK: begin
        if (mask_en_r) begin
          case (count_r[1:0])
            2'd0:    mask_nxt[7:0]   = rx;
            2'd1:    mask_nxt[15:8]  = rx;
            2'd2:    mask_nxt[23:16] = rx;
            default: mask_nxt[31:24] = rx;
          endcase
        end
        count_nxt = count_inc;
        if (count_r[1:0] == 2'd3) begin
          count_nxt = 7'd0;
          if (len_r == 7'd0) begin
            // empty payload completes the frame here
            res_valid  = 1'b1;
            res.frame_done = 1'b1;
            res.status = done_st;
            phase_nxt  = last ? PH_HDR0 : PH_SKIP;
          end else if (last) begin
            res_valid  = 1'b1;
            res.frame_done = 1'b1;
            res.status = ST_TRUNCATED;
            phase_nxt  = PH_HDR0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end else if (last) begin
          res_valid  = 1'b1;
          res.frame_done = 1'b1;
          res.status = ST_TRUNCATED;
          phase_nxt  = PH_HDR0;
        end
      end
      PH_DATA: begin
        count_nxt = count_inc;
        if (count_inc == len_r) begin
          res_valid        = 1'b1;
          res.has_byte     = deliver;
          res.payload_byte = deliver ? (rx ^ mask_byte) : 8'd0;
          res.frame_done   = 1'b1;
          res.status       = done_st;
          phase_nxt        = last ? PH_HDR0 : PH_SKIP;
        end else if (last) begin
          res_valid  = 1'b1;
          res.frame_done = 1'b1;
          res.status = ST_TRUNCATED;
          phase_nxt  = PH_HDR0;
        end else if (deliver) begin
          res_valid        = 1'b1;
          res.has_byte     = 1'b1;
          res.payload_byte = rx ^ mask_byte;
        end
      end
      PH_SKIP: begin
        if (last) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      count_r    <= 7'd0;
      len_r      <= 7'd0;
      mask_r     <= 32'd0;
      mask_en_r  <= 1'b0;
      close_r    <= 1'b0;
      oversize_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      len_r      <= len_nxt;
      mask_r     <= mask_nxt;
      mask_en_r  <= mask_en_nxt;
      close_r    <= close_nxt;
      oversize_r <= oversize_nxt;
    end
  end

endmodule

// File: rtl/wsfu_out_stage.sv
module wsfu_out_stage
  import wsfu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       word_valid,
  input  logic       res_valid,
  input  res_word_t  res,
  output logic       advance,
  wsfu_out_if.source out_ch
);

  logic      valid_r;
  logic      valid_nxt;
  res_word_t res_r;

  // Pipeline moves when the result register is free or being drained
  assign advance = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = word_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && word_valid && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.has_byte     = res_r.has_byte;
  assign out_ch.payload_byte = res_r.payload_byte;
  assign out_ch.frame_done   = res_r.frame_done;
  assign out_ch.status       = res_r.status;

endmodule

// File: rtl/websocket_frame_unmasker_top.sv
// A byte accepted into the input register is parsed combinationally and its result
// word is captured in the result register, where the result side can take it.
// Throughput: one byte per cycle. A result word held by a stalled result side
// stops the parser, and the input stalls once its register holds a word.
// Reset (rst_n, synchronous, active low): parser expects a first header byte,
// counters and mask cleared, both stages empty, max_payload set to 124.
module websocket_frame_unmasker_top
  import wsfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  wsfu_in_if.sink           in_ch,
  wsfu_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic      advance;
  logic      word_valid;
  in_word_t  word;
  logic      res_valid;
  res_word_t res;
  logic [6:0] max_payload;

  wsfu_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  wsfu_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  wsfu_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .word_valid  (word_valid),
    .word        (word),
    .advance     (advance),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsfu_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_ch     (out_ch)
  );

endmodule

// File: tb/sv/wsfu_frame_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts every result word of
// the frame parser and compares the words that leave the block in order.
module wsfu_frame_checker
  import wsfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  wsfu_in_if                in_mon,
  wsfu_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                words_pending
);

  localparam int REPORT_MAX = 10;

  // Predicted parser state
  logic [6:0]  limit_q;
  phase_t      phase_q;
  logic [6:0]  cnt_q;
  logic [6:0]  len_q;
  logic [31:0] mask_q;
  logic        masked_q;
  logic        close_q;
  logic        oversize_q;

  res_word_t expected_words[$];
  int        errors = 0;

  function automatic void push_word(logic has, logic [7:0] b, logic done, status_t st);
    res_word_t w;
    w.has_byte     = has;
    w.payload_byte = has ? b : 8'h00;
    w.frame_done   = done;
    w.status       = done ? st : '0;
    expected_words.push_back(w);
  endfunction

  // too long wins over close
  function automatic status_t done_status();
    if (oversize_q) return ST_TOO_LONG;
    if (close_q) return ST_CLOSE;
    return ST_TEXT;
  endfunction

  // One received byte through the parser
  function automatic void parse_byte(logic [7:0] rx, logic last);
    logic [6:0] lim;
    logic       deliver;
    logic [7:0] b;
    case (phase_q)
      PH_HDR0: begin
        if (!rx[7] || (rx[3:0] != OPC_TEXT && rx[3:0] != OPC_CLOSE)) begin
          push_word(1'b0, 8'h00, 1'b1, ST_BAD_HDR);
          phase_q = last ? PH_HDR0 : PH_SKIP;
        end else begin
          close_q = (rx[3:0] == OPC_CLOSE);
          if (last) begin
            push_word(1'b0, 8'h00, 1'b1, ST_TRUNCATED);
            phase_q = PH_HDR0;
          end else begin
            phase_q = PH_HDR1;
          end
        end
      end
      PH_HDR1: begin
        masked_q   = rx[7];
        len_q      = rx[6:0];
        lim        = (limit_q > LEN_CAP) ? LEN_CAP : limit_q;
        oversize_q = (rx[6:0] > lim);
        cnt_q      = '0;
        mask_q     = '0;
        if (last) begin
          push_word(1'b0, 8'h00, 1'b1, ST_TRUNCATED);
          phase_q = PH_HDR0;
        end else begin
          phase_q = PH_MASK;
        end
      end
      PH_MASK: begin
        // mask bytes are always consumed, kept only with the mask bit
        if (masked_q) mask_q[8*cnt_q[1:0] +: 8] = rx;
        cnt_q = cnt_q + 7'd1;
        if (cnt_q >= 7'd4) begin
          cnt_q = '0;
          if (len_q == '0) begin
            push_word(1'b0, 8'h00, 1'b1, done_status());
            phase_q = last ? PH_HDR0 : PH_SKIP;
            return;
          end
          phase_q = PH_DATA;
        end
        if (last) begin
          push_word(1'b0, 8'h00, 1'b1, ST_TRUNCATED);
          phase_q = PH_HDR0;
        end
      end
      PH_DATA: begin
        deliver = !oversize_q && !close_q;
        b       = rx ^ mask_q[8*cnt_q[1:0] +: 8];
        cnt_q   = cnt_q + 7'd1;
        if (cnt_q == len_q) begin
          push_word(deliver, b, 1'b1, done_status());
          phase_q = last ? PH_HDR0 : PH_SKIP;
        end else if (last) begin
          push_word(1'b0, 8'h00, 1'b1, ST_TRUNCATED);
          phase_q = PH_HDR0;
        end else if (deliver) begin
          push_word(1'b1, b, 1'b0, ST_TEXT);
        end
      end
      default: begin
        // trailing bytes up to the buffer end
        if (last) phase_q = PH_HDR0;
      end
    endcase
  endfunction

  function automatic void report(string what, res_word_t want, res_word_t got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("%t %s: expected has=%0d byte=%02h done=%0d st=%0d, got has=%0d byte=%02h done=%0d st=%0d",
               $realtime, what, want.has_byte, want.payload_byte, want.frame_done, want.status,
               got.has_byte, got.payload_byte, got.frame_done, got.status);
  endfunction

  always @(posedge clk) begin
    res_word_t got;
    res_word_t want;
    if (!rst_n) begin
      limit_q    = MAX_PAYLOAD_RST;
      phase_q    = PH_HDR0;
      cnt_q      = '0;
      len_q      = '0;
      mask_q     = '0;
      masked_q   = 1'b0;
      close_q    = 1'b0;
      oversize_q = 1'b0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_MAX_PAYLOAD, 2'b00})
        limit_q = pwdata[6:0];

      // outgoing word against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.has_byte     = out_mon.has_byte;
        got.payload_byte = out_mon.payload_byte;
        got.frame_done   = out_mon.frame_done;
        got.status       = out_mon.status;
        if (expected_words.size() == 0) begin
          want = '0;
          report("unexpected word", want, got);
        end else begin
          want = expected_words.pop_front();
          if (got.has_byte !== want.has_byte || got.payload_byte !== want.payload_byte ||
              got.frame_done !== want.frame_done || got.status !== want.status)
            report("word mismatch", want, got);
        end
      end

      if (in_mon.valid && in_mon.ready)
        parse_byte(in_mon.rx_byte, in_mon.buffer_end);
    end
    fail_count    <= errors;
    words_pending <= expected_words.size();
  end

endmodule

// File: tb/sv/tb_websocket_frame_unmasker_top.sv
`timescale 1ns / 100ps

module tb_websocket_frame_unmasker_top;
  import wsfu_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_BYTES    = 250;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int          mismatch_total;
  int          words_pending;
  int          idle_cycles = 0;
  int          bytes_sent  = 0;
  bit          in_idle_en  = 1'b1;
  bit          out_idle_en = 1'b1;
  logic [7:0]  frame_q[$];

  always #2 clk = ~clk;

  wsfu_in_if  in_bus ();
  wsfu_out_if out_bus ();

  websocket_frame_unmasker_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  wsfu_frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (mismatch_total),
    .words_pending (words_pending)
  );

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || psel || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** websocket_frame_unmasker_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each word
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = out_idle_en ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.rx_byte    <= b;
    in_bus.buffer_end <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Whole buffer, end flag on its last byte
  task automatic send_buffer();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_PAYLOAD, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, some noise and cut buffers
  task automatic random_frame(input logic [6:0] lim);
    int         kind;
    int         pick;
    int         len;
    int         cut;
    int         eff;
    logic [7:0] b0;
    logic [3:0] op;
    eff  = (lim > LEN_CAP) ? LEN_CAP : lim;
    kind = $urandom_range(0, 99);
    in_idle_en  = ($urandom_range(0, 3) != 0);
    out_idle_en = ($urandom_range(0, 3) != 0);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
    end else if (kind < 18) begin
      b0 = 8'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        b0[7] = 1'b0;
      end else begin
        op = 4'($urandom);
        while (op == OPC_TEXT || op == OPC_CLOSE) op = 4'($urandom);
        b0[7]   = 1'b1;
        b0[3:0] = op;
      end
      frame_q.push_back(b0);
      repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
    end else begin
      op   = ($urandom_range(0, 3) == 0) ? OPC_CLOSE : OPC_TEXT;
      pick = $urandom_range(0, 19);
      if (pick < 16) len = $urandom_range(0, 8);
      else if (pick == 16) len = eff;
      else if (pick == 17) len = (eff < 127) ? eff + 1 : eff;
      else len = $urandom_range(0, 127);
      frame_q.push_back({1'b1, 3'($urandom), op});
      frame_q.push_back({1'($urandom), 7'(len)});
      repeat (4 + len) frame_q.push_back(8'($urandom));
      if ($urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) frame_q.push_back(8'($urandom));
      end
    end
    send_buffer();
  endtask

  initial begin
    logic [6:0] limits[6];
    int         goal;
    limits = '{MAX_PAYLOAD_RST, 7'd0, 7'd127, LEN_CAP, 7'd3, 7'd0};
    limits[5] = 7'($urandom_range(0, 127));

    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.rx_byte    <= 8'h00;
    in_bus.buffer_end <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no FIN; bad opcode then skipped bytes; header cut short
    frame_q = '{8'h01};
    send_buffer();
    frame_q = '{8'hFF, 8'h00, 8'hFF};
    send_buffer();
    frame_q = '{8'h81};
    send_buffer();
    // masked close with empty payload
    frame_q = '{8'h88, 8'h80, 8'hFF, 8'h00, 8'h12, 8'h34};
    send_buffer();
    // masked text, two payload bytes, one trailing byte
    frame_q = '{8'h81, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF, 8'h77};
    send_buffer();
    // buffer ends inside the mask bytes
    frame_q = '{8'h81, 8'h03, 8'h11, 8'h22, 8'h33};
    send_buffer();
    drain();

    // one phase per limit, reset value first
    foreach (limits[p]) begin
      if (p != 0) write_limit(limits[p]);
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) random_frame(limits[p]);
      drain();
    end

    if (mismatch_total == 0 && words_pending == 0) begin
      $display("** websocket_frame_unmasker_top: PASSED **");
    end else begin
      $display("** websocket_frame_unmasker_top: FAILED **");
    end
    $finish;
  end

endmodule
